/* hdl/cmrs_pkg.sv */
// shared constants and register codes of the circular majority run splitter
package cmrs_pkg;

  // default sizes handed to the top level parameters
  localparam int unsigned MAX_POINTS_DEF  = 256;
  localparam int unsigned MAX_RUNS_DEF    = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // two contour stores so loading overlaps processing
  localparam int unsigned NUM_BANKS = 2;

  // fixed field widths
  localparam int unsigned THR_W    = 16;
  localparam int unsigned WIN_W    = 9;
  localparam int unsigned MINRUN_W = 8;
  localparam int unsigned START_W  = 8;
  localparam int unsigned LEN_W    = 9;

  // configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [THR_W-1:0]    THRESHOLD_RST = 16'd0;
  localparam logic [WIN_W-1:0]    WINDOW_RST    = 9'd5;
  localparam logic [MINRUN_W-1:0] MIN_RUN_RST   = 8'd5;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_MIN_RUN   = 2'd2
  } reg_idx_e;

endpackage

/* hdl/cmrs_div.sv */
// iterative restoring divider, one quotient bit per cycle
module cmrs_div #(
  parameter int unsigned DVD_W = 9,
  parameter int unsigned DVS_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int unsigned CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

/* hdl/cmrs_front.sv */
// front end: takes samples, thresholds them and hands finished contours on
module cmrs_front #(
  parameter int unsigned MAX_POINTS  = cmrs_pkg::MAX_POINTS_DEF,
  parameter int unsigned SAMPLE_BITS = cmrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [SAMPLE_BITS-1:0]        sample_value_i,
  input  logic                          last_sample_i,
  input  logic [cmrs_pkg::THR_W-1:0]    threshold_i,
  input  logic                          done_i,
  output logic                          busy_o,
  output logic                          wr_we_o,
  output logic                          wr_bank_o,
  output logic [$clog2(MAX_POINTS)-1:0] wr_addr_o,
  output logic                          wr_above_o,
  output logic                          push_o,
  output logic [$clog2(MAX_POINTS+1)-1:0] push_n_o,
  output logic [$clog2(MAX_POINTS+1)-1:0] push_total_o,
  output logic                          push_ovf_o,
  output logic                          push_bank_o
);

  localparam int unsigned PTR_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMP_W = (SAMPLE_BITS > cmrs_pkg::THR_W) ? SAMPLE_BITS
                                                                  : cmrs_pkg::THR_W;
  localparam int unsigned USE_W = $clog2(cmrs_pkg::NUM_BANKS + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] total_q, total_d;
  logic             ovf_q, ovf_d;
  logic             bank_q, bank_d;
  logic [USE_W-1:0] use_q, use_d;

  logic             accept;
  logic             above;
  logic             store;
  logic [CNT_W-1:0] cnt_nx;
  logic [CNT_W-1:0] total_nx;
  logic             ovf_nx;

  always_comb begin
    busy_o   = (use_q == USE_W'(cmrs_pkg::NUM_BANKS));
    accept   = start_i && !busy_o;
    above    = (CMP_W'(sample_value_i) > CMP_W'(threshold_i));
    store    = (cnt_q != CNT_W'(MAX_POINTS));
    cnt_nx   = store ? cnt_q + 1'b1 : cnt_q;
    total_nx = total_q + CNT_W'(store && above);
    ovf_nx   = ovf_q | !store;

    wr_we_o    = accept && store;
    wr_bank_o  = bank_q;
    wr_addr_o  = cnt_q[PTR_W-1:0];
    wr_above_o = above;

    push_o       = accept && last_sample_i;
    push_n_o     = cnt_nx;
    push_total_o = total_nx;
    push_ovf_o   = ovf_nx;
    push_bank_o  = bank_q;

    cnt_d   = cnt_q;
    total_d = total_q;
    ovf_d   = ovf_q;
    bank_d  = bank_q;
    if (accept) begin
      if (last_sample_i) begin
        cnt_d   = '0;
        total_d = '0;
        ovf_d   = 1'b0;
        bank_d  = ~bank_q;
      end else begin
        cnt_d   = cnt_nx;
        total_d = total_nx;
        ovf_d   = ovf_nx;
      end
    end

    use_d = use_q + USE_W'(push_o) - USE_W'(done_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
      bank_q  <= 1'b0;
      use_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
      bank_q  <= bank_d;
      use_q   <= use_d;
    end
  end

endmodule

/* hdl/cmrs_queue.sv */
// small descriptor queue between front and back
module cmrs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = cmrs_pkg::NUM_BANKS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             vld_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d;
  logic [PW-1:0]    rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    cnt_d  = cnt_q + CW'(push_i) - CW'(pop_i);
    vld_o  = (cnt_q != '0);
    data_o = mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* hdl/cmrs_back.sv */
// back end: majority labeling over the stored bits, then the circular run scan
module cmrs_back #(
  parameter int unsigned MAX_POINTS = cmrs_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_RUNS   = cmrs_pkg::MAX_RUNS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [cmrs_pkg::WIN_W-1:0]       window_i,
  input  logic [cmrs_pkg::MINRUN_W-1:0]    min_run_i,
  input  logic                             wr_we_i,
  input  logic                             wr_bank_i,
  input  logic [$clog2(MAX_POINTS)-1:0]    wr_addr_i,
  input  logic                             wr_above_i,
  input  logic                             desc_vld_i,
  input  logic [$clog2(MAX_POINTS+1)-1:0]  desc_n_i,
  input  logic [$clog2(MAX_POINTS+1)-1:0]  desc_total_i,
  input  logic                             desc_ovf_i,
  input  logic                             desc_bank_i,
  output logic                             pop_o,
  output logic                             done_o,
  output logic                             run_strobe_o,
  output logic [cmrs_pkg::START_W-1:0]     run_start_o,
  output logic [cmrs_pkg::LEN_W-1:0]       run_length_o,
  output logic                             run_valid_o,
  output logic                             overflow_o,
  output logic                             last_run_o
);

  localparam int unsigned PTR_W  = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned KEEP_W = $clog2(MAX_RUNS + 1);
  localparam int unsigned QT_W   = cmrs_pkg::WIN_W + CNT_W;
  localparam int unsigned CT_W   = QT_W + 1;
  localparam int unsigned CMP_W  = (CNT_W > cmrs_pkg::MINRUN_W) ? CNT_W
                                                                : cmrs_pkg::MINRUN_W;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_DIV_Q   = 10'b0000000010,
    ST_DIV_OFF = 10'b0000000100,
    ST_INIT    = 10'b0000001000,
    ST_LAB_RD  = 10'b0000010000,
    ST_LAB_UPD = 10'b0000100000,
    ST_SCAN    = 10'b0001000000,
    ST_TAIL    = 10'b0010000000,
    ST_DONE    = 10'b0100000000,
    ST_SPARE   = 10'b1000000000
  } state_e;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [PTR_W-1:0] last);
    ptr_inc = (p == last) ? '0 : p + 1'b1;
  endfunction

  // stores
  logic above_mem [cmrs_pkg::NUM_BANKS][MAX_POINTS];
  logic lab_mem [MAX_POINTS];
  logic rd_a_q, rd_b_q, lab_rd_q;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   done_q, done_d;

  logic [CNT_W-1:0]          n_q, n_d;
  logic [CNT_W-1:0]          total_q, total_d;
  logic                      sovf_q, sovf_d;
  logic                      bank_q, bank_d;
  logic [cmrs_pkg::WIN_W-1:0] q_q, q_d;
  logic [CNT_W-1:0]          r_q, r_d;
  logic [QT_W-1:0]           qt_q, qt_d;
  logic [PTR_W-1:0]          lo_q, lo_d;
  logic [PTR_W-1:0]          hi_q, hi_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [CNT_W-1:0]          s_q, s_d;
  logic [PTR_W-1:0]          i_q, i_d;
  logic [PTR_W-1:0]          first_q, first_d;
  logic                      found_q, found_d;
  logic [PTR_W-1:0]          p_q, p_d;
  logic [PTR_W-1:0]          pidx_q, pidx_d;
  logic                      in_run_q, in_run_d;
  logic [PTR_W-1:0]          rs_q, rs_d;
  logic [CNT_W-1:0]          len_q, len_d;
  logic [KEEP_W-1:0]         kept_q, kept_d;
  logic                      dropped_q, dropped_d;
  logic                      held_vld_q, held_vld_d;
  logic [PTR_W-1:0]          held_start_q, held_start_d;
  logic [CNT_W-1:0]          held_len_q, held_len_d;

  logic                          out_stb_q, out_stb_d;
  logic [cmrs_pkg::START_W-1:0]  out_start_q, out_start_d;
  logic [cmrs_pkg::LEN_W-1:0]    out_len_q, out_len_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_ovf_q, out_ovf_d;
  logic                          out_last_q, out_last_d;

  // divider hookup
  logic                       div_start;
  logic [cmrs_pkg::WIN_W-1:0] div_dvd;
  logic [CNT_W-1:0]           div_dvs;
  logic                       div_done;
  logic [cmrs_pkg::WIN_W-1:0] div_quot;
  logic [CNT_W-1:0]           div_rem;

  logic [PTR_W-1:0] nm1;
  logic [PTR_W-1:0] lo0;
  logic [PTR_W-1:0] scan_start;
  logic [CT_W-1:0]  count;
  logic             lab_bit;
  logic             lab_we;
  logic             close_en;
  logic             keep_run;

  cmrs_div #(
    .DVD_W (cmrs_pkg::WIN_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    nm1        = PTR_W'(n_q - 1'b1);
    lo0        = (div_rem == '0) ? '0 : PTR_W'(n_q - div_rem);
    scan_start = found_q ? first_q : nm1;
    count      = CT_W'(qt_q) + CT_W'(s_q);
    lab_bit    = ({count, 1'b0} > (CT_W + 1)'(window_i));
    close_en   = ((state_q == ST_SCAN) && pend_q && !lab_rd_q && in_run_q) ||
                 ((state_q == ST_TAIL) && in_run_q);
    keep_run   = close_en && (CMP_W'(len_q) > CMP_W'(min_run_i));
  end

  always_comb begin
    state_d      = state_q;
    pend_d       = 1'b0;
    done_d       = 1'b0;
    n_d          = n_q;
    total_d      = total_q;
    sovf_d       = sovf_q;
    bank_d       = bank_q;
    q_d          = q_q;
    r_d          = r_q;
    qt_d         = qt_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    cnt_d        = cnt_q;
    s_d          = s_q;
    i_d          = i_q;
    first_d      = first_q;
    found_d      = found_q;
    p_d          = p_q;
    pidx_d       = p_q;
    in_run_d     = in_run_q;
    rs_d         = rs_q;
    len_d        = len_q;
    kept_d       = kept_q;
    dropped_d    = dropped_q;
    held_vld_d   = held_vld_q;
    held_start_d = held_start_q;
    held_len_d   = held_len_q;
    out_stb_d    = 1'b0;
    out_start_d  = out_start_q;
    out_len_d    = out_len_q;
    out_valid_d  = out_valid_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;
    pop_o        = 1'b0;
    lab_we       = 1'b0;
    div_start    = 1'b0;
    div_dvd      = window_i;
    div_dvs      = (state_q == ST_IDLE) ? desc_n_i : n_q;

    case (state_q)
      ST_IDLE: begin
        if (desc_vld_i) begin
          pop_o     = 1'b1;
          n_d       = desc_n_i;
          total_d   = desc_total_i;
          sovf_d    = desc_ovf_i;
          bank_d    = desc_bank_i;
          div_start = 1'b1;
          state_d   = ST_DIV_Q;
        end
      end
      ST_DIV_Q: begin
        // window = q*n + r
        if (div_done) begin
          q_d       = div_quot;
          r_d       = div_rem;
          div_start = 1'b1;
          div_dvd   = window_i >> 1;
          state_d   = ST_DIV_OFF;
        end
      end
      ST_DIV_OFF: begin
        // remainder is the window offset, window/2 mod n
        if (div_done) begin
          lo_d    = lo0;
          hi_d    = lo0;
          qt_d    = q_q * total_q;
          cnt_d   = '0;
          s_d     = '0;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        // sum of the first r bits of the partial window
        if (pend_q) begin
          s_d = s_q + CNT_W'(rd_b_q);
        end
        if (cnt_q != r_q) begin
          hi_d   = ptr_inc(hi_q, nm1);
          cnt_d  = cnt_q + 1'b1;
          pend_d = 1'b1;
        end else if (!pend_q) begin
          i_d     = '0;
          found_d = 1'b0;
          state_d = ST_LAB_RD;
        end
      end
      ST_LAB_RD: begin
        lab_we = 1'b1;
        if (!found_q && !lab_bit && (i_q != nm1)) begin
          first_d = i_q;
          found_d = 1'b1;
        end
        state_d = ST_LAB_UPD;
      end
      ST_LAB_UPD: begin
        // slide the partial window by one
        s_d  = s_q + CNT_W'(rd_b_q) - CNT_W'(rd_a_q);
        lo_d = ptr_inc(lo_q, nm1);
        hi_d = ptr_inc(hi_q, nm1);
        if (i_q == nm1) begin
          p_d        = ptr_inc(scan_start, nm1);
          cnt_d      = '0;
          in_run_d   = 1'b0;
          kept_d     = '0;
          dropped_d  = 1'b0;
          held_vld_d = 1'b0;
          state_d    = ST_SCAN;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_LAB_RD;
        end
      end
      ST_SCAN: begin
        if (pend_q) begin
          if (lab_rd_q) begin
            if (in_run_q) begin
              len_d = len_q + 1'b1;
            end else begin
              in_run_d = 1'b1;
              rs_d     = pidx_q;
              len_d    = CNT_W'(1);
            end
          end else begin
            in_run_d = 1'b0;
          end
        end
        if (cnt_q != n_q - 1'b1) begin
          p_d    = ptr_inc(p_q, nm1);
          cnt_d  = cnt_q + 1'b1;
          pend_d = 1'b1;
        end else if (!pend_q) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        in_run_d = 1'b0;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        out_stb_d  = 1'b1;
        out_ovf_d  = dropped_q | sovf_q;
        out_last_d = 1'b1;
        if (held_vld_q) begin
          out_start_d = cmrs_pkg::START_W'(held_start_q);
          out_len_d   = cmrs_pkg::LEN_W'(held_len_q);
          out_valid_d = 1'b1;
        end else begin
          out_start_d = '0;
          out_len_d   = '0;
          out_valid_d = 1'b0;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // closed run: hold the newest kept run, send the one before it
    if (keep_run) begin
      if (kept_q != KEEP_W'(MAX_RUNS)) begin
        if (held_vld_q) begin
          out_stb_d   = 1'b1;
          out_start_d = cmrs_pkg::START_W'(held_start_q);
          out_len_d   = cmrs_pkg::LEN_W'(held_len_q);
          out_valid_d = 1'b1;
          out_ovf_d   = 1'b0;
          out_last_d  = 1'b0;
        end
        held_start_d = rs_q;
        held_len_d   = len_q;
        held_vld_d   = 1'b1;
        kept_d       = kept_q + 1'b1;
      end else begin
        dropped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
      out_stb_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
      out_stb_q <= out_stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    total_q      <= total_d;
    sovf_q       <= sovf_d;
    bank_q       <= bank_d;
    q_q          <= q_d;
    r_q          <= r_d;
    qt_q         <= qt_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    cnt_q        <= cnt_d;
    s_q          <= s_d;
    i_q          <= i_d;
    first_q      <= first_d;
    found_q      <= found_d;
    p_q          <= p_d;
    pidx_q       <= pidx_d;
    in_run_q     <= in_run_d;
    rs_q         <= rs_d;
    len_q        <= len_d;
    kept_q       <= kept_d;
    dropped_q    <= dropped_d;
    held_vld_q   <= held_vld_d;
    held_start_q <= held_start_d;
    held_len_q   <= held_len_d;
    out_start_q  <= out_start_d;
    out_len_q    <= out_len_d;
    out_valid_q  <= out_valid_d;
    out_ovf_q    <= out_ovf_d;
    out_last_q   <= out_last_d;
  end

  // above-threshold bits, one bank per contour, two read ports
  always_ff @(posedge clk_i) begin
    if (wr_we_i) begin
      above_mem[wr_bank_i][wr_addr_i] <= wr_above_i;
    end
    rd_a_q <= above_mem[bank_q][lo_q];
    rd_b_q <= above_mem[bank_q][hi_q];
  end

  // majority labels
  always_ff @(posedge clk_i) begin
    if (lab_we) begin
      lab_mem[i_q] <= lab_bit;
    end
    lab_rd_q <= lab_mem[p_q];
  end

  assign done_o       = done_q;
  assign run_strobe_o = out_stb_q;
  assign run_start_o  = out_start_q;
  assign run_length_o = out_len_q;
  assign run_valid_o  = out_valid_q;
  assign overflow_o   = out_ovf_q;
  assign last_run_o   = out_last_q;

endmodule

/* hdl/circular_majority_run_splitter_unit.sv */
// top level of the circular majority run splitter
//
// a contour is loaded one sample per beat through start/busy; the sample is
// compared against the threshold and only the resulting bit is kept. the beat
// with last_sample set closes the contour, and the block then labels every
// point by a circular majority vote over the window, walks the labels once
// around starting just past the first false label, and sends one beat per
// kept run on the result ports, marked by run_strobe_o for exactly one cycle.
// the receiver cannot stall: every strobed beat must be taken when it shows.
// the final beat of a contour has last_run_o set and carries overflow_o; when
// no run is kept that final beat is an empty marker with run_valid_o low.
// samples beyond MAX_POINTS are dropped and flagged through overflow_o, as are
// runs beyond MAX_RUNS.
//
// loading takes a new sample whenever start is high and busy is low. there
// are two contour stores, so a contour loads while the previous one is
// processed; busy rises only when both stores hold unfinished contours.
// processing a contour runs through these steps in order: the contour is
// taken from the queue; two divider passes run (window by n, window/2 by n;
// nine quotient steps and a done cycle); the partial window sum is primed
// with r bits, r being window mod n; the labeling pass visits a read state
// and an update state per point (both read ports of the bit store are used
// in the update state); the run scan walks the label store; and the tail
// and done states close the last run and send the final beat.
// no clearing pass after reset is needed.
//
// configuration (apb, registers at byte offsets 0x0, 0x4, 0x8):
//   threshold  16 bits, reset 0
//   window      9 bits, reset 5
//   min_run     8 bits, reset 5
// write configuration only while the block is idle.
module circular_majority_run_splitter_unit #(
  parameter int unsigned MAX_POINTS  = cmrs_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_RUNS    = cmrs_pkg::MAX_RUNS_DEF,
  parameter int unsigned SAMPLE_BITS = cmrs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          start,
  output logic                          busy,
  input  logic [SAMPLE_BITS-1:0]        sample_value_i,
  input  logic                          last_sample_i,
  // result channel
  output logic                          run_strobe_o,
  output logic [cmrs_pkg::START_W-1:0]  run_start_o,
  output logic [cmrs_pkg::LEN_W-1:0]    run_length_o,
  output logic                          run_valid_o,
  output logic                          overflow_o,
  output logic                          last_run_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmrs_pkg::ADDR_W-1:0]   paddr,
  input  logic [cmrs_pkg::DATA_W-1:0]   pwdata,
  output logic [cmrs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned PTR_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  // contour descriptor handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] total;
    logic             ovf;
    logic             bank;
  } desc_t;

  // configuration registers
  logic [cmrs_pkg::THR_W-1:0]    threshold_q, threshold_d;
  logic [cmrs_pkg::WIN_W-1:0]    window_q, window_d;
  logic [cmrs_pkg::MINRUN_W-1:0] min_run_q, min_run_d;
  logic                          cfg_wr;

  // front to back
  logic             wr_we;
  logic             wr_bank;
  logic [PTR_W-1:0] wr_addr;
  logic             wr_above;
  logic             push;
  desc_t            push_desc;
  logic             pop;
  logic             desc_vld;
  desc_t            desc;
  logic             done;

  // write decode, one register per word
  always_comb begin
    cfg_wr      = psel && penable && pwrite;
    threshold_d = threshold_q;
    window_d    = window_q;
    min_run_d   = min_run_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        cmrs_pkg::REG_THRESHOLD: threshold_d = pwdata[cmrs_pkg::THR_W-1:0];
        cmrs_pkg::REG_WINDOW:    window_d    = pwdata[cmrs_pkg::WIN_W-1:0];
        cmrs_pkg::REG_MIN_RUN:   min_run_d   = pwdata[cmrs_pkg::MINRUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read mux, unused offsets read zero
  always_comb begin
    case (paddr[3:2])
      cmrs_pkg::REG_THRESHOLD: prdata = cmrs_pkg::DATA_W'(threshold_q);
      cmrs_pkg::REG_WINDOW:    prdata = cmrs_pkg::DATA_W'(window_q);
      cmrs_pkg::REG_MIN_RUN:   prdata = cmrs_pkg::DATA_W'(min_run_q);
      default:                 prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= cmrs_pkg::THRESHOLD_RST;
      window_q    <= cmrs_pkg::WINDOW_RST;
      min_run_q   <= cmrs_pkg::MIN_RUN_RST;
    end else begin
      threshold_q <= threshold_d;
      window_q    <= window_d;
      min_run_q   <= min_run_d;
    end
  end

  // sample intake and thresholding
  cmrs_front #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sample_value_i (sample_value_i),
    .last_sample_i  (last_sample_i),
    .threshold_i    (threshold_q),
    .done_i         (done),
    .busy_o         (busy),
    .wr_we_o        (wr_we),
    .wr_bank_o      (wr_bank),
    .wr_addr_o      (wr_addr),
    .wr_above_o     (wr_above),
    .push_o         (push),
    .push_n_o       (push_desc.n),
    .push_total_o   (push_desc.total),
    .push_ovf_o     (push_desc.ovf),
    .push_bank_o    (push_desc.bank)
  );

  // finished contours wait here until the back end is free
  cmrs_queue #(
    .WIDTH ($bits(desc_t)),
    .DEPTH (cmrs_pkg::NUM_BANKS)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_desc),
    .pop_i  (pop),
    .vld_o  (desc_vld),
    .data_o (desc)
  );

  // labeling, run scan and result beats
  cmrs_back #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_RUNS   (MAX_RUNS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .window_i     (window_q),
    .min_run_i    (min_run_q),
    .wr_we_i      (wr_we),
    .wr_bank_i    (wr_bank),
    .wr_addr_i    (wr_addr),
    .wr_above_i   (wr_above),
    .desc_vld_i   (desc_vld),
    .desc_n_i     (desc.n),
    .desc_total_i (desc.total),
    .desc_ovf_i   (desc.ovf),
    .desc_bank_i  (desc.bank),
    .pop_o        (pop),
    .done_o       (done),
    .run_strobe_o (run_strobe_o),
    .run_start_o  (run_start_o),
    .run_length_o (run_length_o),
    .run_valid_o  (run_valid_o),
    .overflow_o   (overflow_o),
    .last_run_o   (last_run_o)
  );

endmodule
